// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the token lexer checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TOKL_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TOKL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/tokl_pkg.sv -----
// ----------------------------------------------------------------------------
// tokl_pkg
// Token kinds, character codes, result word type and helpers for the lexer.
// ----------------------------------------------------------------------------
`default_nettype none

package tokl_pkg;

    // Depth of the result queue (power of two, at least 2)
    localparam int TOKL_QUEUE_DEPTH = 4;

    // Token kinds
    localparam logic [3:0] KIND_STRING    = 4'd0;
    localparam logic [3:0] KIND_URI       = 4'd1;
    localparam logic [3:0] KIND_DIRECTIVE = 4'd2;
    localparam logic [3:0] KIND_INTEGER   = 4'd3;
    localparam logic [3:0] KIND_NAME      = 4'd4;
    localparam logic [3:0] KIND_COMMA     = 4'd5;
    localparam logic [3:0] KIND_DOT       = 4'd6;
    localparam logic [3:0] KIND_SEMI      = 4'd7;
    localparam logic [3:0] KIND_CARETS    = 4'd8;
    localparam logic [3:0] KIND_FINISHED  = 4'd9;

    // Character codes
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_T  = 8'h74;

    typedef struct packed {
        logic [3:0] kind;
        logic [7:0] data;
        logic       data_valid;
        logic       last;
        logic       error;
    } tokl_result_t;

    function automatic tokl_result_t tokl_data(input logic [3:0] kind,
                                               input logic [7:0] data);
        tokl_result_t r;
        r.kind       = kind;
        r.data       = data;
        r.data_valid = 1'b1;
        r.last       = 1'b0;
        r.error      = 1'b0;
        return r;
    endfunction

    function automatic tokl_result_t tokl_close(input logic [3:0] kind);
        tokl_result_t r;
        r.kind       = kind;
        r.data       = 8'h00;
        r.data_valid = 1'b0;
        r.last       = 1'b1;
        r.error      = 1'b0;
        return r;
    endfunction

    function automatic tokl_result_t tokl_fail();
        tokl_result_t r;
        r.kind       = KIND_FINISHED;
        r.data       = 8'h00;
        r.data_valid = 1'b0;
        r.last       = 1'b1;
        r.error      = 1'b1;
        return r;
    endfunction

    function automatic logic tokl_is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic tokl_is_lower(input logic [7:0] c);
        return (c >= 8'h61) && (c <= 8'h7A);
    endfunction

    function automatic logic tokl_is_name(input logic [7:0] c);
        return tokl_is_lower(c) || ((c >= 8'h41) && (c <= 8'h5A)) ||
               (c == CH_UNDER) || (c == CH_COLON) || c[7];
    endfunction

endpackage

`default_nettype wire

// ----- design/tokl_in_if.sv -----
// ----------------------------------------------------------------------------
// tokl_in_if
// Byte channel into the lexer: one text byte or end mark per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface tokl_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_input;

    modport source (output valid, output in_byte, output end_of_input, input ready);
    modport sink   (input valid, input in_byte, input end_of_input, output ready);
    modport mon    (input valid, input in_byte, input end_of_input, input ready);
endinterface

`default_nettype wire

// ----- design/tokl_out_if.sv -----
// ----------------------------------------------------------------------------
// tokl_out_if
// Token channel out of the lexer: one result word per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface tokl_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] token_kind;
    logic [7:0] data_byte;
    logic       data_valid;
    logic       token_last;
    logic       lex_error;

    modport source (output valid, output token_kind, output data_byte,
                    output data_valid, output token_last, output lex_error,
                    input ready);
    modport sink   (input valid, input token_kind, input data_byte,
                    input data_valid, input token_last, input lex_error,
                    output ready);
    modport mon    (input valid, input token_kind, input data_byte,
                    input data_valid, input token_last, input lex_error,
                    input ready);
endinterface

`default_nettype wire

// ----- design/tokl_core.sv -----
// ----------------------------------------------------------------------------
// tokl_core
// Lexer state machine: one byte per step, up to two result words per step.
// ----------------------------------------------------------------------------
`default_nettype none

module tokl_core
    import tokl_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         step,
    input  wire logic [7:0]   in_byte,
    input  wire logic         end_of_input,
    output tokl_result_t      res0,
    output tokl_result_t      res1,
    output logic [1:0]        res_valid
);

    typedef enum logic [3:0] {
        LS_IDLE,
        LS_COMMENT,
        LS_STRING,
        LS_STRING_ESC,
        LS_URI,
        LS_URI_ESC,
        LS_CARET,
        LS_DIRECTIVE,
        LS_SIGN,
        LS_INTEGER,
        LS_NAME
    } lex_state_t;

    lex_state_t   state_reg, state_next;
    logic [7:0]   sign_reg, sign_next;
    logic         stop_reg, stop_next;

    // Start-of-token decode of the current byte
    lex_state_t   start_state;
    logic         start_sign;
    logic         start_emit;
    logic         start_fail;
    tokl_result_t start_res;

    // Escape decode
    logic [7:0]   closer;
    logic [3:0]   q_kind;
    logic         esc_ok;
    logic [7:0]   esc_val;

    // Two ordered slots: a prefix (a closing word or the held sign) and a main word
    logic         a_v, b_v, use_start, fail;
    tokl_result_t a_r, b_r;

    always_comb
    begin
        start_state = LS_IDLE;
        start_sign  = 1'b0;
        start_emit  = 1'b0;
        start_fail  = 1'b0;
        start_res   = tokl_close(KIND_FINISHED);
        case (in_byte)
            CH_TAB, CH_LF, CH_CR, CH_SPACE: ;
            CH_QUOTE: start_state = LS_STRING;
            CH_HASH:  start_state = LS_COMMENT;
            CH_COMMA:
            begin
                start_emit = 1'b1;
                start_res  = tokl_close(KIND_COMMA);
            end
            CH_DOT:
            begin
                start_emit = 1'b1;
                start_res  = tokl_close(KIND_DOT);
            end
            CH_SEMI:
            begin
                start_emit = 1'b1;
                start_res  = tokl_close(KIND_SEMI);
            end
            CH_LT:    start_state = LS_URI;
            CH_CARET: start_state = LS_CARET;
            CH_AT:    start_state = LS_DIRECTIVE;
            CH_PLUS, CH_MINUS:
            begin
                start_sign  = 1'b1;
                start_state = LS_SIGN;
            end
            default:
            begin
                if (tokl_is_digit(in_byte))
                begin
                    start_state = LS_INTEGER;
                    start_emit  = 1'b1;
                    start_res   = tokl_data(KIND_INTEGER, in_byte);
                end
                else if (tokl_is_name(in_byte))
                begin
                    start_state = LS_NAME;
                    start_emit  = 1'b1;
                    start_res   = tokl_data(KIND_NAME, in_byte);
                end
                else
                begin
                    start_fail = 1'b1;
                end
            end
        endcase
    end

    always_comb
    begin
        closer  = (state_reg == LS_URI_ESC) ? CH_GT : CH_QUOTE;
        q_kind  = (state_reg == LS_URI_ESC) ? KIND_URI : KIND_STRING;
        esc_ok  = 1'b1;
        esc_val = closer;
        if (in_byte == CH_BSLASH)
            esc_val = CH_BSLASH;
        else if (in_byte == CH_LOW_T)
            esc_val = CH_TAB;
        else if (in_byte == CH_LOW_N)
            esc_val = CH_LF;
        else if (in_byte == CH_LOW_R)
            esc_val = CH_CR;
        else if (in_byte != closer)
            esc_ok = 1'b0;
    end

    always_comb
    begin
        state_next = state_reg;
        sign_next  = sign_reg;
        stop_next  = stop_reg;
        a_v        = 1'b0;
        b_v        = 1'b0;
        a_r        = tokl_close(KIND_FINISHED);
        b_r        = tokl_close(KIND_FINISHED);
        use_start  = 1'b0;
        fail       = 1'b0;

        if (stop_reg)
        begin
            fail = 1'b1;
        end
        else if (end_of_input)
        begin
            state_next = LS_IDLE;
            b_v        = 1'b1;
            case (state_reg)
                LS_IDLE, LS_COMMENT: ;
                LS_DIRECTIVE:
                begin
                    a_v = 1'b1;
                    a_r = tokl_close(KIND_DIRECTIVE);
                end
                LS_INTEGER:
                begin
                    a_v = 1'b1;
                    a_r = tokl_close(KIND_INTEGER);
                end
                LS_NAME:
                begin
                    a_v = 1'b1;
                    a_r = tokl_close(KIND_NAME);
                end
                default: fail = 1'b1;
            endcase
        end
        else
        begin
            case (state_reg)
                LS_IDLE: use_start = 1'b1;
                LS_COMMENT:
                begin
                    if (in_byte == CH_LF || in_byte == CH_CR)
                        state_next = LS_IDLE;
                end
                LS_STRING, LS_URI:
                begin
                    b_v = 1'b1;
                    if (in_byte == CH_BSLASH)
                    begin
                        b_v        = 1'b0;
                        state_next = (state_reg == LS_URI) ? LS_URI_ESC : LS_STRING_ESC;
                    end
                    else if ((state_reg == LS_URI && in_byte == CH_GT) ||
                             (state_reg == LS_STRING && in_byte == CH_QUOTE))
                    begin
                        state_next = LS_IDLE;
                        b_r = tokl_close((state_reg == LS_URI) ? KIND_URI : KIND_STRING);
                    end
                    else
                    begin
                        b_r = tokl_data((state_reg == LS_URI) ? KIND_URI : KIND_STRING,
                                        in_byte);
                    end
                end
                LS_STRING_ESC, LS_URI_ESC:
                begin
                    if (esc_ok)
                    begin
                        b_v        = 1'b1;
                        b_r        = tokl_data(q_kind, esc_val);
                        state_next = (state_reg == LS_URI_ESC) ? LS_URI : LS_STRING;
                    end
                    else
                    begin
                        fail = 1'b1;
                    end
                end
                LS_CARET:
                begin
                    if (in_byte == CH_CARET)
                    begin
                        state_next = LS_IDLE;
                        b_v        = 1'b1;
                        b_r        = tokl_close(KIND_CARETS);
                    end
                    else
                    begin
                        fail = 1'b1;
                    end
                end
                LS_DIRECTIVE:
                begin
                    if (in_byte == CH_MINUS || tokl_is_lower(in_byte) ||
                        tokl_is_digit(in_byte))
                    begin
                        b_v = 1'b1;
                        b_r = tokl_data(KIND_DIRECTIVE, in_byte);
                    end
                    else
                    begin
                        a_v       = 1'b1;
                        a_r       = tokl_close(KIND_DIRECTIVE);
                        use_start = 1'b1;
                    end
                end
                LS_SIGN:
                begin
                    if (tokl_is_digit(in_byte))
                    begin
                        a_v        = 1'b1;
                        a_r        = tokl_data(KIND_INTEGER, sign_reg);
                        b_v        = 1'b1;
                        b_r        = tokl_data(KIND_INTEGER, in_byte);
                        sign_next  = 8'h00;
                        state_next = LS_INTEGER;
                    end
                    else if (tokl_is_name(in_byte))
                    begin
                        // drop the sign, the name starts at this byte
                        sign_next = 8'h00;
                        use_start = 1'b1;
                    end
                    else
                    begin
                        fail = 1'b1;
                    end
                end
                LS_INTEGER:
                begin
                    if (tokl_is_digit(in_byte))
                    begin
                        b_v = 1'b1;
                        b_r = tokl_data(KIND_INTEGER, in_byte);
                    end
                    else
                    begin
                        a_v       = 1'b1;
                        a_r       = tokl_close(KIND_INTEGER);
                        use_start = 1'b1;
                    end
                end
                LS_NAME:
                begin
                    if (tokl_is_name(in_byte))
                    begin
                        b_v = 1'b1;
                        b_r = tokl_data(KIND_NAME, in_byte);
                    end
                    else
                    begin
                        a_v       = 1'b1;
                        a_r       = tokl_close(KIND_NAME);
                        use_start = 1'b1;
                    end
                end
                default: fail = 1'b1;
            endcase
        end

        if (use_start)
        begin
            state_next = start_state;
            if (start_sign)
                sign_next = in_byte;
            b_v  = start_emit;
            b_r  = start_res;
            fail = start_fail;
        end

        // Error: stop for good, emit the error word after any prefix
        if (fail)
        begin
            stop_next  = 1'b1;
            state_next = LS_IDLE;
            sign_next  = 8'h00;
            b_v        = 1'b1;
            b_r        = tokl_fail();
        end
    end

    // Compact the two slots so word 0 always comes first
    always_comb
    begin
        if (a_v)
        begin
            res0      = a_r;
            res1      = b_r;
            res_valid = {b_v, 1'b1};
        end
        else
        begin
            res0      = b_r;
            res1      = a_r;
            res_valid = {1'b0, b_v};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= LS_IDLE;
            sign_reg  <= 8'h00;
            stop_reg  <= 1'b0;
        end
        else if (step)
        begin
            state_reg <= state_next;
            sign_reg  <= sign_next;
            stop_reg  <= stop_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/tokl_outq.sv -----
// ----------------------------------------------------------------------------
// tokl_outq
// Small result queue: takes up to two words per cycle, gives one per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tokl_outq
    import tokl_pkg::*;
#(
    parameter int DEPTH = TOKL_QUEUE_DEPTH
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic [1:0]   push,
    input  wire tokl_result_t res0,
    input  wire tokl_result_t res1,
    input  wire logic         pop,
    output tokl_result_t      head,
    output logic              not_empty,
    output logic              room
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    tokl_result_t           entry_reg [DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [PTR_W-1:0]       wr_ptr_inc;

    assign wr_ptr_inc = wr_ptr_reg + PTR_W'(1);
    assign head       = entry_reg[rd_ptr_reg];
    assign not_empty  = (count_reg != '0);
    // room for a full two-word step
    assign room       = (count_reg <= CNT_W'(DEPTH - 2));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push[0]) + PTR_W'(push[1]);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(push[0]) + CNT_W'(push[1]) - CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push[0])
            entry_reg[wr_ptr_reg] <= res0;
        if (push[1])
            entry_reg[wr_ptr_inc] <= res1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/turtle_token_lexer.sv -----
// ----------------------------------------------------------------------------
// turtle_token_lexer
// Streaming Turtle tokenizer: text bytes in, tagged token words out.
// ----------------------------------------------------------------------------
// The lexer takes one text byte (or an end-of-input mark) per word on the
// text channel and sends result words on the tokens channel: content bytes
// tagged with the token kind, then a closing word with token_last set.
// It accepts one byte per clock cycle while the result queue has room. Each
// byte is held in an input register, runs through the lexer state machine
// while held there and lands as zero, one or two words in a result queue
// (TOKL_QUEUE_DEPTH words by default); the tokens channel drains the queue
// at one word per cycle while ready is high. The first word of a byte is
// offered once the byte has passed the input register and the queue.
// A byte that yields two words (a token closed by the byte that starts
// the next, a signed integer's first digit, or end of input inside a
// token) writes both into the queue together; the text channel stalls
// only when the queue has fewer than two free slots. After a lexing error
// the block answers every further word with one error word until reset.
// ----------------------------------------------------------------------------
`default_nettype none

module turtle_token_lexer
    import tokl_pkg::*;
#(
    parameter int QUEUE_DEPTH = TOKL_QUEUE_DEPTH
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    tokl_in_if.sink       text,
    tokl_out_if.source    tokens
);

    // Input register
    logic         in_valid_reg, in_valid_next;
    logic [7:0]   in_byte_reg;
    logic         in_eoi_reg;

    logic         accept;
    logic         step;
    logic         room;

    tokl_result_t res0, res1, head;
    logic [1:0]   res_valid;
    logic         q_not_empty;

    // Advance the held byte once the queue can take a whole step
    assign step       = in_valid_reg && room;
    assign text.ready = !in_valid_reg || step;
    assign accept     = text.valid && text.ready;

    always_comb
    begin
        if (accept)
            in_valid_next = 1'b1;
        else if (step)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    // Hold payload until the next accepted word
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_byte_reg <= text.in_byte;
            in_eoi_reg  <= text.end_of_input;
        end
    end

    tokl_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .in_byte      (in_byte_reg),
        .end_of_input (in_eoi_reg),
        .res0         (res0),
        .res1         (res1),
        .res_valid    (res_valid)
    );

    tokl_outq #(
        .DEPTH (QUEUE_DEPTH)
    ) u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid & {2{step}}),
        .res0      (res0),
        .res1      (res1),
        .pop       (tokens.valid && tokens.ready),
        .head      (head),
        .not_empty (q_not_empty),
        .room      (room)
    );

    // Drive the result word from the queue head
    assign tokens.valid      = q_not_empty;
    assign tokens.token_kind = head.kind;
    assign tokens.data_byte  = head.data;
    assign tokens.data_valid = head.data_valid;
    assign tokens.token_last = head.last;
    assign tokens.lex_error  = head.error;

endmodule

`default_nettype wire

// ----- design/tokl_checker.sv -----
// ----------------------------------------------------------------------------
// tokl_checker
// Port-level checks on the lexer output, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module tokl_checker
    import tokl_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         valid,
    input  wire logic         ready,
    input  wire logic [3:0]   token_kind,
    input  wire logic [7:0]   data_byte,
    input  wire logic         data_valid,
    input  wire logic         token_last,
    input  wire logic         lex_error
);

    logic         err_seen_reg, err_seen_next;
    logic         stall;
    logic [14:0]  word;
    logic         err_shape_ok;
    logic         data_open_ok;

    assign err_seen_next = err_seen_reg || (valid && ready && lex_error);
    assign stall         = valid && !ready;
    assign word          = {token_kind, data_byte, data_valid, token_last, lex_error};
    assign err_shape_ok  = (token_kind == KIND_FINISHED) && token_last && !data_valid;
    assign data_open_ok  = !token_last && !lex_error;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            err_seen_reg <= 1'b0;
        else
            err_seen_reg <= err_seen_next;
    end

    `TOKL_ASSERT_NEXT(a_out_hold, clk, rst_n, stall, valid && $stable(word), "word changed in stall")
    `TOKL_ASSERT_IMPLY(a_err_sticky, clk, rst_n, valid && err_seen_reg, lex_error, "clean word after error")
    `TOKL_ASSERT_IMPLY(a_err_shape, clk, rst_n, valid && lex_error, err_shape_ok, "malformed error word")
    `TOKL_ASSERT_IMPLY(a_data_open, clk, rst_n, valid && data_valid, data_open_ok, "content word has last")

endmodule

bind turtle_token_lexer tokl_checker u_tokl_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .valid      (tokens.valid),
    .ready      (tokens.ready),
    .token_kind (tokens.token_kind),
    .data_byte  (tokens.data_byte),
    .data_valid (tokens.data_valid),
    .token_last (tokens.token_last),
    .lex_error  (tokens.lex_error)
);

`default_nettype wire

// ----- sim/turtle_token_lexer_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// turtle_token_lexer_tb
// Self-checking bench for the streaming Turtle tokenizer.
// ----------------------------------------------------------------------------
// A short directed walk goes through every token kind, the escaped closers,
// the lone sign, the byte extremes and end of input. A long run of randomly
// built Turtle text follows, ending in one randomly chosen broken sequence
// and a burst of noise that must come back as sticky error words. Each
// accepted text word is run through a behavioral copy of the lexer, and
// every token word is checked field by field against the oldest prediction.
// Both channels idle at random, the receiver holds off once for a long
// stretch and the sender once waits for the token stream to drain.
// ----------------------------------------------------------------------------

module turtle_token_lexer_tb;
    import tokl_pkg::*;

    // Run shape
    localparam int unsigned RANDOM_WORDS = 1000;
    localparam int unsigned NOISE_WORDS  = 30;
    localparam int unsigned HOLD_AT      = 300;
    localparam int unsigned HOLD_CYCLES  = 80;
    localparam int unsigned BURST_LEN    = 60;
    localparam int unsigned DRAIN_AT     = 650;
    localparam int unsigned SETTLE       = 20;
    localparam int unsigned QUIET_LIMIT  = 2000;
    localparam int unsigned MAX_REPORTS  = 10;

    // Character range bounds
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_LOW_Z = 8'h7A;

    typedef enum logic [3:0] {
        LX_IDLE,
        LX_COMMENT,
        LX_STRING,
        LX_STRING_ESC,
        LX_URI,
        LX_URI_ESC,
        LX_CARET,
        LX_DIRECTIVE,
        LX_SIGN,
        LX_INTEGER,
        LX_NAME
    } lex_state_t;

    // Ways to end the clean part of the stream with a lexing error
    typedef enum int {
        BREAK_BAD_START,
        BREAK_STRING_ESC,
        BREAK_URI_ESC,
        BREAK_SINGLE_CARET,
        BREAK_BARE_SIGN,
        BREAK_EOI_STRING,
        BREAK_EOI_URI,
        BREAK_EOI_CARET,
        BREAK_EOI_SIGN,
        BREAK_EOI_ESCAPE
    } break_kind_t;

    typedef struct {
        logic [7:0]   b;
        logic         eoi;
        bit           typed;
        int unsigned  n_typed;
        tokl_result_t w0;
        tokl_result_t w1;
    } text_item_t;

    logic clk;
    logic rst_n;

    tokl_in_if  text_if ();
    tokl_out_if tok_if ();

    turtle_token_lexer dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text_if),
        .tokens (tok_if)
    );

    // Lexer copy: state, the sign held back and the sticky stop
    lex_state_t   lx_state;
    logic [7:0]   lx_sign;
    bit           lx_halted;
    tokl_result_t step_words[$];   // words caused by the current text word
    tokl_result_t due_words[$];    // predicted words not yet seen on tokens

    text_item_t   text_plan[$];
    int unsigned  directed_len;
    break_kind_t  tail_break;

    bit           hold_request;
    bit           plan_done;
    int unsigned  fail_count;
    int unsigned  text_taken;
    int unsigned  words_checked;
    int unsigned  error_words;
    logic [9:0]   kinds_closed;
    int unsigned  quiet_cycles;
    tokl_result_t got_word;
    tokl_result_t want_word;

    // ------------------------------------------------------------------------
    // Character classes
    // ------------------------------------------------------------------------
    function automatic bit is_dec(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic bit is_word_char(input logic [7:0] c);
        return ((c >= CH_LOW_A) && (c <= CH_LOW_Z)) ||
               ((c >= CH_UP_A) && (c <= CH_UP_Z)) ||
               (c == CH_UNDER) || (c == CH_COLON) || (c >= 8'h80);
    endfunction

    function automatic bit is_dir_char(input logic [7:0] c);
        return (c == CH_MINUS) || ((c >= CH_LOW_A) && (c <= CH_LOW_Z)) || is_dec(c);
    endfunction

    function automatic bit starts_token(input logic [7:0] c);
        case (c)
            CH_TAB, CH_LF, CH_CR, CH_SPACE, CH_QUOTE, CH_HASH, CH_COMMA, CH_DOT,
            CH_SEMI, CH_LT, CH_CARET, CH_AT, CH_PLUS, CH_MINUS:
                return 1'b1;
            default:
                return is_dec(c) || is_word_char(c);
        endcase
    endfunction

    function automatic tokl_result_t mk_word(input logic [3:0] kind, input logic [7:0] data,
                                             input logic dv, input logic last,
                                             input logic err);
        tokl_result_t w;
        w.kind       = kind;
        w.data       = data;
        w.data_valid = dv;
        w.last       = last;
        w.error      = err;
        return w;
    endfunction

    // ------------------------------------------------------------------------
    // Lexer copy
    // ------------------------------------------------------------------------
    task automatic emit_data(input logic [3:0] kind, input logic [7:0] data);
        step_words.push_back(mk_word(kind, data, 1'b1, 1'b0, 1'b0));
    endtask

    task automatic emit_close(input logic [3:0] kind);
        step_words.push_back(mk_word(kind, 8'h00, 1'b0, 1'b1, 1'b0));
    endtask

    task automatic halt_lexer();
        lx_halted = 1'b1;
        lx_state  = LX_IDLE;
        lx_sign   = 8'h00;
        step_words.push_back(mk_word(KIND_FINISHED, 8'h00, 1'b0, 1'b1, 1'b1));
    endtask

    // Decide what a byte seen between tokens opens
    task automatic begin_token(input logic [7:0] b);
        lx_state = LX_IDLE;
        case (b)
            CH_TAB, CH_LF, CH_CR, CH_SPACE: ;
            CH_QUOTE: lx_state = LX_STRING;
            CH_HASH:  lx_state = LX_COMMENT;
            CH_COMMA: emit_close(KIND_COMMA);
            CH_DOT:   emit_close(KIND_DOT);
            CH_SEMI:  emit_close(KIND_SEMI);
            CH_LT:    lx_state = LX_URI;
            CH_CARET: lx_state = LX_CARET;
            CH_AT:    lx_state = LX_DIRECTIVE;
            CH_PLUS, CH_MINUS:
            begin
                lx_sign  = b;
                lx_state = LX_SIGN;
            end
            default:
            begin
                if (is_dec(b))
                begin
                    lx_state = LX_INTEGER;
                    emit_data(KIND_INTEGER, b);
                end
                else if (is_word_char(b))
                begin
                    lx_state = LX_NAME;
                    emit_data(KIND_NAME, b);
                end
                else
                    halt_lexer();
            end
        endcase
    endtask

    // Body of a string or URI
    task automatic quoted_byte(input logic [7:0] b, input logic [7:0] closer,
                               input logic [3:0] kind, input lex_state_t esc_state);
        if (b == CH_BSLASH)
            lx_state = esc_state;
        else if (b == closer)
        begin
            lx_state = LX_IDLE;
            emit_close(kind);
        end
        else
            emit_data(kind, b);
    endtask

    // Byte after a backslash
    task automatic escape_byte(input logic [7:0] b, input logic [7:0] closer,
                               input logic [3:0] kind, input lex_state_t body_state);
        logic [7:0] decoded;
        bit         ok;
        ok = 1'b1;
        if (b == CH_BSLASH)
            decoded = CH_BSLASH;
        else if (b == CH_LOW_T)
            decoded = CH_TAB;
        else if (b == CH_LOW_N)
            decoded = CH_LF;
        else if (b == CH_LOW_R)
            decoded = CH_CR;
        else if (b == closer)
            decoded = closer;
        else
        begin
            decoded = 8'h00;
            ok      = 1'b0;
        end
        if (!ok)
            halt_lexer();
        else
        begin
            lx_state = body_state;
            emit_data(kind, decoded);
        end
    endtask

    // Advance the lexer copy by one text word; results land in step_words
    task automatic lex_step(input logic [7:0] b, input logic eoi);
        step_words.delete();
        if (lx_halted)
        begin
            step_words.push_back(mk_word(KIND_FINISHED, 8'h00, 1'b0, 1'b1, 1'b1));
            return;
        end
        if (eoi)
        begin
            case (lx_state)
                LX_IDLE, LX_COMMENT: ;
                LX_DIRECTIVE: emit_close(KIND_DIRECTIVE);
                LX_INTEGER:   emit_close(KIND_INTEGER);
                LX_NAME:      emit_close(KIND_NAME);
                default:
                begin
                    halt_lexer();
                    return;
                end
            endcase
            lx_state = LX_IDLE;
            emit_close(KIND_FINISHED);
            return;
        end
        case (lx_state)
            LX_IDLE:
                begin_token(b);
            LX_COMMENT:
                if (b == CH_LF || b == CH_CR)
                    lx_state = LX_IDLE;
            LX_STRING:
                quoted_byte(b, CH_QUOTE, KIND_STRING, LX_STRING_ESC);
            LX_STRING_ESC:
                escape_byte(b, CH_QUOTE, KIND_STRING, LX_STRING);
            LX_URI:
                quoted_byte(b, CH_GT, KIND_URI, LX_URI_ESC);
            LX_URI_ESC:
                escape_byte(b, CH_GT, KIND_URI, LX_URI);
            LX_CARET:
            begin
                if (b == CH_CARET)
                begin
                    lx_state = LX_IDLE;
                    emit_close(KIND_CARETS);
                end
                else
                    halt_lexer();
            end
            LX_DIRECTIVE:
            begin
                if (is_dir_char(b))
                    emit_data(KIND_DIRECTIVE, b);
                else
                begin
                    emit_close(KIND_DIRECTIVE);
                    begin_token(b);
                end
            end
            LX_SIGN:
            begin
                // A digit releases the held sign; a name character drops it
                if (is_dec(b))
                begin
                    emit_data(KIND_INTEGER, lx_sign);
                    lx_sign  = 8'h00;
                    lx_state = LX_INTEGER;
                    emit_data(KIND_INTEGER, b);
                end
                else if (is_word_char(b))
                begin
                    lx_sign = 8'h00;
                    begin_token(b);
                end
                else
                    halt_lexer();
            end
            LX_INTEGER:
            begin
                if (is_dec(b))
                    emit_data(KIND_INTEGER, b);
                else
                begin
                    emit_close(KIND_INTEGER);
                    begin_token(b);
                end
            end
            LX_NAME:
            begin
                if (is_word_char(b))
                    emit_data(KIND_NAME, b);
                else
                begin
                    emit_close(KIND_NAME);
                    begin_token(b);
                end
            end
            default:
                halt_lexer();
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Stimulus plan
    // ------------------------------------------------------------------------
    task automatic queue_byte(input logic [7:0] b, input logic eoi);
        text_item_t it;
        it.b       = b;
        it.eoi     = eoi;
        it.typed   = 1'b0;
        it.n_typed = 0;
        it.w0      = '0;
        it.w1      = '0;
        text_plan.push_back(it);
    endtask

    task automatic queue_checked(input logic [7:0] b, input logic eoi, input int unsigned n,
                                 input tokl_result_t w0, input tokl_result_t w1);
        text_item_t it;
        it.b       = b;
        it.eoi     = eoi;
        it.typed   = 1'b1;
        it.n_typed = n;
        it.w0      = w0;
        it.w1      = w1;
        text_plan.push_back(it);
    endtask

    function automatic logic [7:0] any_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] pick_name_char();
        case ($urandom_range(0, 4))
            0: return 8'($urandom_range(CH_LOW_A, CH_LOW_Z));
            1: return 8'($urandom_range(CH_UP_A, CH_UP_Z));
            2: return ($urandom_range(0, 1) != 0) ? CH_UNDER : CH_COLON;
            default: return 8'($urandom_range(8'h80, 8'hFF));
        endcase
    endfunction

    function automatic logic [7:0] pick_dir_char();
        case ($urandom_range(0, 2))
            0: return CH_MINUS;
            1: return 8'($urandom_range(CH_LOW_A, CH_LOW_Z));
            default: return 8'($urandom_range(CH_ZERO, CH_NINE));
        endcase
    endfunction

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(0, 3))
            0: return CH_TAB;
            1: return CH_LF;
            2: return CH_CR;
            default: return CH_SPACE;
        endcase
    endfunction

    function automatic logic [7:0] pick_sign();
        return ($urandom_range(0, 1) != 0) ? CH_PLUS : CH_MINUS;
    endfunction

    // String or URI with random raw content and legal escapes
    task automatic plan_quoted(input logic [7:0] opener, input logic [7:0] closer);
        int unsigned len;
        logic [7:0]  c;
        queue_byte(opener, 1'b0);
        len = $urandom_range(0, 10);
        repeat (len)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                queue_byte(CH_BSLASH, 1'b0);
                case ($urandom_range(0, 4))
                    0: c = CH_BSLASH;
                    1: c = CH_LOW_T;
                    2: c = CH_LOW_N;
                    3: c = CH_LOW_R;
                    default: c = closer;
                endcase
                queue_byte(c, 1'b0);
            end
            else
            begin
                do
                    c = any_byte();
                while (c == CH_BSLASH || c == closer);
                queue_byte(c, 1'b0);
            end
        end
        queue_byte(closer, 1'b0);
    endtask

    // One well-formed token (or blank, comment, end mark) with random content
    task automatic plan_token();
        int unsigned len;
        logic [7:0]  c;
        case ($urandom_range(0, 99)) inside
            [0:9]:
            begin
                len = $urandom_range(1, 3);
                repeat (len) queue_byte(pick_blank(), 1'b0);
            end
            [10:15]:
            begin
                queue_byte(CH_HASH, 1'b0);
                len = $urandom_range(0, 8);
                repeat (len)
                begin
                    do
                        c = any_byte();
                    while (c == CH_LF || c == CH_CR);
                    queue_byte(c, 1'b0);
                end
                queue_byte(($urandom_range(0, 1) != 0) ? CH_LF : CH_CR, 1'b0);
            end
            [16:31]: plan_quoted(CH_QUOTE, CH_QUOTE);
            [32:43]: plan_quoted(CH_LT, CH_GT);
            [44:51]:
            begin
                queue_byte(CH_AT, 1'b0);
                len = $urandom_range(0, 5);
                repeat (len) queue_byte(pick_dir_char(), 1'b0);
            end
            [52:65]:
            begin
                if ($urandom_range(0, 2) == 0)
                    queue_byte(pick_sign(), 1'b0);
                len = $urandom_range(1, 5);
                repeat (len) queue_byte(8'($urandom_range(CH_ZERO, CH_NINE)), 1'b0);
            end
            [66:81]:
            begin
                // A lone sign in front of a name is dropped by the lexer
                if ($urandom_range(0, 5) == 0)
                    queue_byte(pick_sign(), 1'b0);
                queue_byte(pick_name_char(), 1'b0);
                len = $urandom_range(0, 6);
                repeat (len) queue_byte(pick_name_char(), 1'b0);
            end
            [82:91]:
            begin
                case ($urandom_range(0, 2))
                    0: queue_byte(CH_COMMA, 1'b0);
                    1: queue_byte(CH_DOT, 1'b0);
                    default: queue_byte(CH_SEMI, 1'b0);
                endcase
            end
            [92:95]:
            begin
                queue_byte(CH_CARET, 1'b0);
                queue_byte(CH_CARET, 1'b0);
            end
            default: queue_byte(any_byte(), 1'b1);
        endcase
    endtask

    // Broken sequence that stops the lexer, then noise it must keep refusing
    task automatic plan_break();
        logic [7:0] c;
        queue_byte(CH_SPACE, 1'b0);
        tail_break = break_kind_t'($urandom_range(0, 9));
        case (tail_break)
            BREAK_BAD_START:
            begin
                do
                    c = any_byte();
                while (starts_token(c));
                queue_byte(c, 1'b0);
            end
            BREAK_STRING_ESC, BREAK_URI_ESC:
            begin
                queue_byte((tail_break == BREAK_STRING_ESC) ? CH_QUOTE : CH_LT, 1'b0);
                queue_byte(CH_BSLASH, 1'b0);
                do
                    c = any_byte();
                while (c == CH_BSLASH || c == CH_LOW_T || c == CH_LOW_N || c == CH_LOW_R ||
                       c == ((tail_break == BREAK_STRING_ESC) ? CH_QUOTE : CH_GT));
                queue_byte(c, 1'b0);
            end
            BREAK_SINGLE_CARET:
            begin
                queue_byte(CH_CARET, 1'b0);
                do
                    c = any_byte();
                while (c == CH_CARET);
                queue_byte(c, 1'b0);
            end
            BREAK_BARE_SIGN:
            begin
                queue_byte(pick_sign(), 1'b0);
                do
                    c = any_byte();
                while (is_dec(c) || is_word_char(c));
                queue_byte(c, 1'b0);
            end
            BREAK_EOI_STRING:
            begin
                queue_byte(CH_QUOTE, 1'b0);
                queue_byte(any_byte(), 1'b1);
            end
            BREAK_EOI_URI:
            begin
                queue_byte(CH_LT, 1'b0);
                queue_byte(any_byte(), 1'b1);
            end
            BREAK_EOI_CARET:
            begin
                queue_byte(CH_CARET, 1'b0);
                queue_byte(any_byte(), 1'b1);
            end
            BREAK_EOI_SIGN:
            begin
                queue_byte(pick_sign(), 1'b0);
                queue_byte(any_byte(), 1'b1);
            end
            default:
            begin
                queue_byte(CH_QUOTE, 1'b0);
                queue_byte(CH_BSLASH, 1'b0);
                queue_byte(any_byte(), 1'b1);
            end
        endcase
        repeat (NOISE_WORDS) queue_byte(any_byte(), ($urandom_range(0, 3) == 0));
    endtask

    task automatic build_plan();
        // Directed walk: rows with a typed expectation are the ones that can
        // be read straight off the spec; the rest go through the lexer copy.
        queue_checked(8'hFF, 1'b1, 1, mk_word(KIND_FINISHED, 8'h00, 1'b0, 1'b1, 1'b0), '0);
        queue_byte(CH_QUOTE, 1'b0);
        queue_checked(8'h00, 1'b0, 1, mk_word(KIND_STRING, 8'h00, 1'b1, 1'b0, 1'b0), '0);
        queue_checked(8'hFF, 1'b0, 1, mk_word(KIND_STRING, 8'hFF, 1'b1, 1'b0, 1'b0), '0);
        queue_byte(CH_BSLASH, 1'b0);     // escaped closing quote
        queue_byte(CH_QUOTE, 1'b0);
        queue_byte(CH_QUOTE, 1'b0);
        queue_byte(CH_LT, 1'b0);         // URI with escaped closer
        queue_byte(CH_BSLASH, 1'b0);
        queue_byte(CH_GT, 1'b0);
        queue_byte(CH_GT, 1'b0);
        queue_byte(CH_AT, 1'b0);         // directive ended by a blank
        queue_byte(8'h70, 1'b0);
        queue_byte(CH_SPACE, 1'b0);
        queue_byte(CH_MINUS, 1'b0);      // signed integer ended by a comma
        queue_byte(CH_ZERO + 8'd7, 1'b0);
        queue_byte(CH_COMMA, 1'b0);
        queue_byte(CH_PLUS, 1'b0);       // lone sign dropped before a name
        queue_byte(8'h78, 1'b0);
        queue_byte(8'h80, 1'b0);
        queue_byte(CH_DOT, 1'b0);        // name ended by a dot
        queue_byte(CH_CARET, 1'b0);
        queue_byte(CH_CARET, 1'b0);
        queue_byte(CH_HASH, 1'b0);       // comment closed by carriage return
        queue_byte(CH_CR, 1'b0);
        queue_byte(CH_SEMI, 1'b0);
        queue_byte(CH_NINE, 1'b0);
        queue_checked(8'h00, 1'b1, 2, mk_word(KIND_INTEGER, 8'h00, 1'b0, 1'b1, 1'b0),
                      mk_word(KIND_FINISHED, 8'h00, 1'b0, 1'b1, 1'b0));
        directed_len = text_plan.size();

        // Random Turtle text, adjacent tokens half the time
        while (text_plan.size() < directed_len + RANDOM_WORDS)
        begin
            plan_token();
            if ($urandom_range(0, 1) != 0)
                queue_byte(pick_blank(), 1'b0);
        end
        plan_break();
    endtask

    // ------------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------------
    // Text sender: draws a gap before every word, predicts on acceptance
    // ------------------------------------------------------------------------
    initial
    begin : byte_sender
        text_item_t  it;
        int unsigned idx;
        int unsigned gap;
        bit          tx_steady;

        text_if.valid        <= 1'b0;
        text_if.in_byte      <= 8'h00;
        text_if.end_of_input <= 1'b0;
        hold_request = 1'b0;
        plan_done    = 1'b0;
        tx_steady    = 1'b0;
        lx_state     = LX_IDLE;
        lx_sign      = 8'h00;
        lx_halted    = 1'b0;
        build_plan();

        @(posedge clk);
        while (!rst_n) @(posedge clk);

        for (idx = 0; idx < text_plan.size(); idx++)
        begin
            it = text_plan[idx];
            if (idx % 50 == 0)
                tx_steady = ($urandom_range(0, 3) == 0);

            // Ask the receiver to hold off while we keep offering words
            if (idx == HOLD_AT)
                hold_request = 1'b1;

            // Drop valid and wait for every predicted word to come out
            if (idx == DRAIN_AT)
            begin
                text_if.valid <= 1'b0;
                do
                    @(posedge clk);
                while (due_words.size() != 0);
            end

            if (tx_steady || (idx >= HOLD_AT && idx < HOLD_AT + BURST_LEN))
                gap = 0;
            else
                gap = $urandom_range(0, 9);
            if (gap != 0)
            begin
                text_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end

            text_if.valid        <= 1'b1;
            text_if.in_byte      <= it.b;
            text_if.end_of_input <= it.eoi;
            do
                @(posedge clk);
            while (!text_if.ready);

            // Word taken at this edge: advance the lexer copy
            text_taken++;
            lex_step(it.b, it.eoi);
            if (it.typed)
            begin
                due_words.push_back(it.w0);
                if (it.n_typed > 1)
                    due_words.push_back(it.w1);
            end
            else
                foreach (step_words[i]) due_words.push_back(step_words[i]);
        end
        text_if.valid <= 1'b0;
        plan_done = 1'b1;
    end

    // ------------------------------------------------------------------------
    // Token receiver: draws a stall before every word, one long hold-off
    // ------------------------------------------------------------------------
    initial
    begin : token_receiver
        int unsigned gap;
        int unsigned taken;
        bit          rx_steady;

        tok_if.ready <= 1'b0;
        taken     = 0;
        rx_steady = 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);

        forever
        begin
            if (taken % 50 == 0)
                rx_steady = ($urandom_range(0, 3) == 0);
            if (hold_request)
            begin
                // Hold ready low long enough for the result queue to fill
                hold_request = 1'b0;
                tok_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            gap = rx_steady ? 0 : $urandom_range(0, 9);
            if (gap != 0)
            begin
                tok_if.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            tok_if.ready <= 1'b1;
            do
                @(posedge clk);
            while (!tok_if.valid);
            taken++;
        end
    end

    // ------------------------------------------------------------------------
    // Token checker
    // ------------------------------------------------------------------------
    task automatic note_failure(input string what, input tokl_result_t want,
                                input tokl_result_t got);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
        begin
            $display("%t %s: want kind %0d data %02h dv %0b last %0b err %0b",
                     $time, what, want.kind, want.data, want.data_valid, want.last,
                     want.error);
            $display("%t %s: got  kind %0d data %02h dv %0b last %0b err %0b",
                     $time, what, got.kind, got.data, got.data_valid, got.last,
                     got.error);
        end
    endtask

    initial
    begin
        fail_count    = 0;
        text_taken    = 0;
        words_checked = 0;
        error_words   = 0;
        kinds_closed  = '0;
        quiet_cycles  = 0;
    end

    always @(posedge clk)
    begin
        if (rst_n && tok_if.valid && tok_if.ready)
        begin
            got_word = mk_word(tok_if.token_kind, tok_if.data_byte, tok_if.data_valid,
                               tok_if.token_last, tok_if.lex_error);
            words_checked++;
            if (got_word.error)
                error_words++;
            else if (got_word.last && got_word.kind <= KIND_FINISHED)
                kinds_closed[got_word.kind] = 1'b1;

            if (due_words.size() == 0)
                note_failure("token word with nothing predicted", '0, got_word);
            else
            begin
                want_word = due_words.pop_front();
                if (got_word.kind !== want_word.kind || got_word.data !== want_word.data ||
                    got_word.data_valid !== want_word.data_valid ||
                    got_word.last !== want_word.last || got_word.error !== want_word.error)
                    note_failure("token word mismatch", want_word, got_word);
            end
        end
    end

    // Watchdog: end the run when neither channel moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((text_if.valid && text_if.ready) || (tok_if.valid && tok_if.ready))
                quiet_cycles <= 0;
            else if (quiet_cycles + 1 >= QUIET_LIMIT)
            begin
                $display("%t watchdog: no word moved for %0d cycles, %0d still predicted",
                         $time, QUIET_LIMIT, due_words.size());
                $display("== FAIL ==");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // End of run
    // ------------------------------------------------------------------------
    initial
    begin : run_end
        wait (plan_done);
        while (due_words.size() != 0) @(posedge clk);
        // Let any stray word surface before judging
        repeat (SETTLE) @(posedge clk);
        if (due_words.size() != 0)
        begin
            fail_count++;
            $display("%t %0d predicted token words never arrived", $time, due_words.size());
        end
        $display("Lexed %0d text words (%0d directed) into %0d token words, %0d of them errors.",
                 text_taken, directed_len, words_checked, error_words);
        $display("Token kinds closed cleanly: mask %b; stream ended by %s.",
                 kinds_closed, tail_break.name());
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
